// ===== rtl/ptt_pkg.sv =====
// Package for the periodic task timer table: sizes, command codes, FSM states
// and the structs that pass between the sequencer, slot store and compare unit.
// No dependencies.
`timescale 1ns / 1ps

package ptt_pkg;

  localparam int MAX_TIMERS  = 16;
  localparam int MAX_RESULTS = 16;
  localparam int IDX_W   = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int CNT_W   = $clog2(MAX_TIMERS + 1);
  localparam int RES_W   = $clog2(MAX_RESULTS + 1);
  localparam int TAG_W   = 8;
  localparam int TIME_W  = 32;
  localparam int COUNT_W = 5;

  typedef enum logic [2:0] {
    K_ADD   = 3'd0,
    K_SET   = 3'd1,
    K_START = 3'd2,
    K_STOP  = 3'd3,
    K_RESET = 3'd4,
    K_QUERY = 3'd5,
    K_COUNT = 3'd6,
    K_POLL  = 3'd7
  } ptt_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMD,
    ST_SEARCH,
    ST_POLL
  } ptt_state_t;

  typedef enum logic {
    CMP_TAG,
    CMP_EXP
  } ptt_cmp_mode_t;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [TIME_W-1:0] interval;
    logic [TIME_W-1:0] last_ev;
    logic              enabled;
  } ptt_slot_t;

  typedef struct packed {
    logic [IDX_W-1:0] addr;
    logic             we_tag;
    logic             we_interval;
    logic             we_last;
    logic             we_enabled;
    ptt_slot_t        data;
  } ptt_wr_t;

  typedef struct packed {
    logic               valid;
    logic               ok;
    logic               enabled_flag;
    logic [COUNT_W-1:0] task_count;
    logic               fired;
    logic [TAG_W-1:0]   fired_tag;
    logic               last;
  } ptt_res_t;

endpackage

// ===== rtl/ptt_slot_store.sv =====
// Slot store: tag, interval, last-event time and enable bit of every timer.
// One write port with per-field enables, one read port. Depends on ptt_pkg.
`timescale 1ns / 1ps

module ptt_slot_store import ptt_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  ptt_wr_t          wr,
  input  logic [IDX_W-1:0] rd_addr,
  output ptt_slot_t        rd_slot
);

  logic [TAG_W-1:0]      tag_r      [MAX_TIMERS];
  logic [TIME_W-1:0]     interval_r [MAX_TIMERS];
  logic [TIME_W-1:0]     last_ev_r  [MAX_TIMERS];
  logic [MAX_TIMERS-1:0] enabled_r;

  always_ff @(posedge clk) begin
    if (wr.we_tag) begin
      tag_r[wr.addr] <= wr.data.tag;
    end
    if (wr.we_interval) begin
      interval_r[wr.addr] <= wr.data.interval;
    end
    if (wr.we_last) begin
      last_ev_r[wr.addr] <= wr.data.last_ev;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= '0;
    end else if (wr.we_enabled) begin
      enabled_r[wr.addr] <= wr.data.enabled;
    end
  end

  assign rd_slot.tag      = tag_r[rd_addr];
  assign rd_slot.interval = interval_r[rd_addr];
  assign rd_slot.last_ev  = last_ev_r[rd_addr];
  assign rd_slot.enabled  = enabled_r[rd_addr];

endmodule

// ===== rtl/ptt_cmp_unit.sv =====
// Shared compare unit: one 32-bit subtractor serves both the tag match of a
// search and the expiry test of a poll. Depends on ptt_pkg.
`timescale 1ns / 1ps

module ptt_cmp_unit import ptt_pkg::*; (
  input  ptt_cmp_mode_t     mode,
  input  ptt_slot_t         slot,
  input  logic [TAG_W-1:0]  cmd_tag,
  input  logic [TIME_W-1:0] cmd_now,
  output logic              hit
);

  logic [TIME_W-1:0] op_a;
  logic [TIME_W-1:0] op_b;
  logic [TIME_W-1:0] diff;

  always_comb begin
    case (mode)
      CMP_TAG: begin
        op_a = TIME_W'(slot.tag);
        op_b = TIME_W'(cmd_tag);
      end
      default: begin
        op_a = cmd_now;
        op_b = slot.last_ev;
      end
    endcase
  end

  assign diff = op_a - op_b;

  always_comb begin
    case (mode)
      CMP_TAG: hit = (diff == '0);
      default: hit = (diff > slot.interval);
    endcase
  end

endmodule

// ===== rtl/ptt_seq.sv =====
// Sequencer: takes a command, walks the slots one per cycle through the
// compare unit, issues slot writes and result transactions. Depends on ptt_pkg.
`timescale 1ns / 1ps

module ptt_seq import ptt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [2:0]        kind,
  input  logic [TAG_W-1:0]  task_tag,
  input  logic [TIME_W-1:0] interval,
  input  logic              enable_on_add,
  input  logic [TIME_W-1:0] now,
  output logic              busy,
  output logic [IDX_W-1:0]  rd_addr,
  input  ptt_slot_t         slot,
  input  logic              hit,
  output ptt_cmp_mode_t     cmp_mode,
  output logic [TAG_W-1:0]  cmd_tag,
  output logic [TIME_W-1:0] cmd_now,
  output ptt_wr_t           wr,
  output ptt_res_t          res
);

  ptt_state_t state_r, state_nxt;

  ptt_kind_t         kind_r;
  logic [TAG_W-1:0]  tag_r;
  logic [TIME_W-1:0] interval_r;
  logic              en_add_r;
  logic [TIME_W-1:0] now_r;

  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  used_r, used_nxt;
  logic [RES_W-1:0]  nfire_r, nfire_nxt;
  logic              pend_r, pend_nxt;
  logic [TAG_W-1:0]  pend_tag_r, pend_tag_nxt;

  logic scan_end;
  logic poll_done;

  assign scan_end  = (idx_r >= used_r);
  assign poll_done = scan_end || (nfire_r >= RES_W'(MAX_RESULTS));

  assign busy     = (state_r != ST_IDLE);
  assign rd_addr  = idx_r[IDX_W-1:0];
  assign cmd_tag  = tag_r;
  assign cmd_now  = now_r;
  assign cmp_mode = (state_r == ST_POLL) ? CMP_EXP : CMP_TAG;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (ptt_kind_t'(kind))
            K_ADD, K_COUNT: state_nxt = ST_CMD;
            K_POLL:         state_nxt = ST_POLL;
            default:        state_nxt = ST_SEARCH;
          endcase
        end
      end
      ST_CMD: state_nxt = ST_IDLE;
      ST_SEARCH: begin
        if (scan_end || hit) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_POLL: begin
        if (poll_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath control, slot writes and results.
  always_comb begin
    wr           = '0;
    wr.addr      = idx_r[IDX_W-1:0];
    res          = '0;
    idx_nxt      = idx_r;
    used_nxt     = used_r;
    nfire_nxt    = nfire_r;
    pend_nxt     = pend_r;
    pend_tag_nxt = pend_tag_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          idx_nxt   = '0;
          nfire_nxt = '0;
          pend_nxt  = 1'b0;
        end
      end
      ST_CMD: begin
        res.valid = 1'b1;
        res.last  = 1'b1;
        if (kind_r == K_ADD) begin
          if (used_r < CNT_W'(MAX_TIMERS)) begin
            wr.addr          = used_r[IDX_W-1:0];
            wr.we_tag        = 1'b1;
            wr.we_interval   = 1'b1;
            wr.we_last       = 1'b1;
            wr.we_enabled    = 1'b1;
            wr.data.tag      = tag_r;
            wr.data.interval = interval_r;
            wr.data.last_ev  = now_r;
            wr.data.enabled  = en_add_r;
            used_nxt         = CNT_W'(used_r + 1'b1);
            res.ok           = 1'b1;
          end
        end else begin
          res.ok = 1'b1;
        end
      end
      ST_SEARCH: begin
        if (scan_end) begin
          res.valid = 1'b1;
          res.last  = 1'b1;
        end else if (hit) begin
          res.valid = 1'b1;
          res.last  = 1'b1;
          res.ok    = 1'b1;
          case (kind_r)
            K_SET: begin
              wr.we_interval   = 1'b1;
              wr.data.interval = interval_r;
            end
            K_START: begin
              wr.we_enabled   = 1'b1;
              wr.data.enabled = 1'b1;
              wr.we_last      = !slot.enabled;
              wr.data.last_ev = now_r;
            end
            K_STOP: begin
              wr.we_enabled   = 1'b1;
              wr.data.enabled = 1'b0;
            end
            K_RESET: begin
              wr.we_last      = 1'b1;
              wr.data.last_ev = now_r;
            end
            K_QUERY: res.enabled_flag = slot.enabled;
            default: ;
          endcase
        end else begin
          idx_nxt = CNT_W'(idx_r + 1'b1);
        end
      end
      ST_POLL: begin
        if (poll_done) begin
          // The held-back fire (if any) goes out marked as the final one.
          res.valid     = 1'b1;
          res.last      = 1'b1;
          res.ok        = 1'b1;
          res.fired     = pend_r;
          res.fired_tag = pend_r ? pend_tag_r : '0;
        end else begin
          idx_nxt = CNT_W'(idx_r + 1'b1);
          if (slot.enabled && hit) begin
            wr.we_last      = 1'b1;
            wr.data.last_ev = now_r;
            if (pend_r) begin
              res.valid     = 1'b1;
              res.ok        = 1'b1;
              res.fired     = 1'b1;
              res.fired_tag = pend_tag_r;
            end
            pend_nxt     = 1'b1;
            pend_tag_nxt = slot.tag;
            nfire_nxt    = RES_W'(nfire_r + 1'b1);
          end
        end
      end
      default: ;
    endcase
    res.task_count = COUNT_W'(used_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      used_r  <= '0;
      idx_r   <= '0;
      nfire_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      idx_r   <= idx_nxt;
      nfire_r <= nfire_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_tag_r <= pend_tag_nxt;
    if (start && !busy) begin
      kind_r     <= ptt_kind_t'(kind);
      tag_r      <= task_tag;
      interval_r <= interval;
      en_add_r   <= enable_on_add;
      now_r      <= now;
    end
  end

endmodule

// ===== rtl/periodic_task_timer_table.sv =====
// Top level of the periodic task timer table: sequencer, slot store, shared
// compare unit and the result output register. Depends on ptt_pkg and submodules.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                     Payload
// command   in         start, busy                   in_kind, in_task_tag, in_interval,
//                                                    in_enable_on_add, in_now
// result    out        out_valid (one-cycle strobe)  out_ok, out_enabled_flag,
//                                                    out_task_count, out_fired,
//                                                    out_fired_tag, out_last
//
// A command transaction is taken when start is high and busy is low. Add and count
// are done in the command state; a tag search walks the used slots until a match,
// and a poll walks all used slots; both are paced by the single read port of the
// slot store and the one compare unit, which look at one slot per cycle.
// Each result shows on the out_ ports for exactly one cycle, in the cycle after the
// sequencer produces it; the receiver cannot stall. Synchronous active-low reset
// clears the slot count, the enable bits and the sequencer; other slot fields are
// written by add before any command can read them.

module periodic_task_timer_table import ptt_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [2:0]          in_kind,
  input  logic [TAG_W-1:0]    in_task_tag,
  input  logic [TIME_W-1:0]   in_interval,
  input  logic                in_enable_on_add,
  input  logic [TIME_W-1:0]   in_now,
  output logic                out_valid,
  output logic                out_ok,
  output logic                out_enabled_flag,
  output logic [COUNT_W-1:0]  out_task_count,
  output logic                out_fired,
  output logic [TAG_W-1:0]    out_fired_tag,
  output logic                out_last
);

  logic [IDX_W-1:0]  rd_addr;
  ptt_slot_t         slot;
  logic              hit;
  ptt_cmp_mode_t     cmp_mode;
  logic [TAG_W-1:0]  cmd_tag;
  logic [TIME_W-1:0] cmd_now;
  ptt_wr_t           wr;
  ptt_res_t          res;

  logic               out_valid_r;
  logic               out_ok_r;
  logic               out_enabled_flag_r;
  logic [COUNT_W-1:0] out_task_count_r;
  logic               out_fired_r;
  logic [TAG_W-1:0]   out_fired_tag_r;
  logic               out_last_r;

  // The sequencer owns the command registers, the slot count and the walk index.
  ptt_seq u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .kind          (in_kind),
    .task_tag      (in_task_tag),
    .interval      (in_interval),
    .enable_on_add (in_enable_on_add),
    .now           (in_now),
    .busy          (busy),
    .rd_addr       (rd_addr),
    .slot          (slot),
    .hit           (hit),
    .cmp_mode      (cmp_mode),
    .cmd_tag       (cmd_tag),
    .cmd_now       (cmd_now),
    .wr            (wr),
    .res           (res)
  );

  // Slot fields; the write port serves add, the addressed commands and poll reloads.
  ptt_slot_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_slot (slot)
  );

  // Tag match during a search, expiry test during a poll.
  ptt_cmp_unit u_cmp (
    .mode    (cmp_mode),
    .slot    (slot),
    .cmd_tag (cmd_tag),
    .cmd_now (cmd_now),
    .hit     (hit)
  );

  // Result register: the strobe is reset, the payload simply follows.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_ok_r           <= res.ok;
    out_enabled_flag_r <= res.enabled_flag;
    out_task_count_r   <= res.task_count;
    out_fired_r        <= res.fired;
    out_fired_tag_r    <= res.fired_tag;
    out_last_r         <= res.last;
  end

  assign out_valid        = out_valid_r;
  assign out_ok           = out_ok_r;
  assign out_enabled_flag = out_enabled_flag_r;
  assign out_task_count   = out_task_count_r;
  assign out_fired        = out_fired_r;
  assign out_fired_tag    = out_fired_tag_r;
  assign out_last         = out_last_r;

endmodule

// ===== rtl/ptt_checker.sv =====
// Port-level checker for the periodic task timer table and its bind statement.
// Depends on ptt_pkg and periodic_task_timer_table.
`timescale 1ns / 1ps

module ptt_checker import ptt_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input logic                out_last
);

  // An accepted command keeps the block busy in the following cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("command accepted but block not busy next cycle");

  // More results of a poll are still to come, so the block must still be busy.
  a_more_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy)
    else $error("non-final result while block idle");

  // Every result comes from work done in the previous cycle.
  a_valid_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without preceding work");

  // The final result of a command is never directly followed by another result.
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !out_valid)
    else $error("result directly after a final result");

endmodule

bind periodic_task_timer_table ptt_checker u_ptt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_last  (out_last)
);
